>>> rtl/jacm_pkg.sv
// Package for the calibrated joystick axis map.
// Shared widths, register codes, reset values and calibration structs.
// No dependencies.
package jacm_pkg;

  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 8;
  localparam int SPAN_W   = 8;
  // diff * span peaks at 255 * 128, which fits in 15 bits
  localparam int PROD_W   = 15;
  // quotient bits resolved per divider stage
  localparam int DIV_BPS  = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_X_LOW  = 3'd0,
    REG_X_MID  = 3'd1,
    REG_X_HIGH = 3'd2,
    REG_Y_LOW  = 3'd3,
    REG_Y_MID  = 3'd4,
    REG_Y_HIGH = 3'd5,
    REG_OUT_LO = 3'd6,
    REG_OUT_HI = 3'd7
  } reg_idx_t;

  localparam logic [7:0] LOW_RST    = 8'd0;
  localparam logic [7:0] MID_RST    = 8'd128;
  localparam logic [7:0] HIGH_RST   = 8'd255;
  localparam logic [7:0] OUT_LO_RST = 8'h9C;  // -100
  localparam logic [6:0] OUT_HI_RST = 7'd100;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] mid;
    logic [7:0] hi;
  } axis_cal_t;

  typedef struct packed {
    axis_cal_t  x;
    axis_cal_t  y;
    logic [7:0] out_low;
    logic [6:0] out_high;
  } cal_t;

endpackage

>>> rtl/jacm_regs.sv
// Calibration register file behind an APB-style port.
// Depends on jacm_pkg.
module jacm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jacm_pkg::ADDR_W-1:0] paddr,
  input  logic [jacm_pkg::DATA_W-1:0] pwdata,
  output logic [jacm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output jacm_pkg::cal_t              cal
);

  jacm_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = jacm_pkg::reg_idx_t'(paddr[jacm_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.x.lo     <= jacm_pkg::LOW_RST;
      cal.x.mid    <= jacm_pkg::MID_RST;
      cal.x.hi     <= jacm_pkg::HIGH_RST;
      cal.y.lo     <= jacm_pkg::LOW_RST;
      cal.y.mid    <= jacm_pkg::MID_RST;
      cal.y.hi     <= jacm_pkg::HIGH_RST;
      cal.out_low  <= jacm_pkg::OUT_LO_RST;
      cal.out_high <= jacm_pkg::OUT_HI_RST;
    end else if (wr) begin
      unique case (idx)
        jacm_pkg::REG_X_LOW:  cal.x.lo     <= pwdata[7:0];
        jacm_pkg::REG_X_MID:  cal.x.mid    <= pwdata[7:0];
        jacm_pkg::REG_X_HIGH: cal.x.hi     <= pwdata[7:0];
        jacm_pkg::REG_Y_LOW:  cal.y.lo     <= pwdata[7:0];
        jacm_pkg::REG_Y_MID:  cal.y.mid    <= pwdata[7:0];
        jacm_pkg::REG_Y_HIGH: cal.y.hi     <= pwdata[7:0];
        jacm_pkg::REG_OUT_LO: cal.out_low  <= pwdata[7:0];
        jacm_pkg::REG_OUT_HI: cal.out_high <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jacm_pkg::REG_X_LOW:  prdata = {24'd0, cal.x.lo};
      jacm_pkg::REG_X_MID:  prdata = {24'd0, cal.x.mid};
      jacm_pkg::REG_X_HIGH: prdata = {24'd0, cal.x.hi};
      jacm_pkg::REG_Y_LOW:  prdata = {24'd0, cal.y.lo};
      jacm_pkg::REG_Y_MID:  prdata = {24'd0, cal.y.mid};
      jacm_pkg::REG_Y_HIGH: prdata = {24'd0, cal.y.hi};
      jacm_pkg::REG_OUT_LO: prdata = {24'd0, cal.out_low};
      jacm_pkg::REG_OUT_HI: prdata = {25'd0, cal.out_high};
    endcase
  end

endmodule

>>> rtl/jacm_div_stage.sv
// One stage of the pipelined restoring divider: BPS quotient bits per stage.
// Depends on jacm_pkg.
module jacm_div_stage #(
  parameter int BPS   = jacm_pkg::DIV_BPS,
  parameter int NUM_W = jacm_pkg::PROD_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [7:0]       rem_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [NUM_W-1:0] quo_in,
  input  logic [7:0]       den_in,
  input  logic             seg_in,
  output logic [7:0]       rem_out,
  output logic [NUM_W-1:0] num_out,
  output logic [NUM_W-1:0] quo_out,
  output logic [7:0]       den_out,
  output logic             seg_out
);

  logic [7:0]       rem_next;
  logic [NUM_W-1:0] num_next;
  logic [NUM_W-1:0] quo_next;

  always_comb begin
    logic [8:0] r2;
    logic       ge;
    rem_next = rem_in;
    num_next = num_in;
    quo_next = quo_in;
    for (int j = 0; j < BPS; j++) begin
      r2       = {rem_next, num_next[NUM_W-1]};
      num_next = {num_next[NUM_W-2:0], 1'b0};
      ge       = r2 >= {1'b0, den_in};
      // zero divisor gives junk here; the final stage forces the result
      rem_next = ge ? 8'(r2 - {1'b0, den_in}) : r2[7:0];
      quo_next = {quo_next[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      num_out <= num_next;
      quo_out <= quo_next;
      den_out <= den_in;
      seg_out <= seg_in;
    end
  end

endmodule

>>> rtl/jacm_lane.sv
// Datapath of one axis: clamp/select, multiply, divider stages, offset/saturate.
// Depends on jacm_pkg and jacm_div_stage.
module jacm_lane #(
  parameter int DIV_BPS = jacm_pkg::DIV_BPS,
  localparam int DIV_STAGES = (jacm_pkg::PROD_W + DIV_BPS - 1) / DIV_BPS,
  localparam int NUM_W      = DIV_STAGES * DIV_BPS,
  localparam int NSTG       = DIV_STAGES + 3
) (
  input  logic                          clk,
  input  logic [NSTG-1:0]               en,
  input  logic [jacm_pkg::SAMPLE_W-1:0] sample,
  input  jacm_pkg::axis_cal_t           cal,
  input  logic [7:0]                    out_low,
  input  logic [6:0]                    out_high,
  output logic [jacm_pkg::POS_W-1:0]    pos
);

  // stage 0: clamp and segment select
  logic [7:0] v_lo, v_cl, start, endp, diff_c, den_c, span_c;
  logic       seg_c;

  always_comb begin
    v_lo   = (sample < cal.lo) ? cal.lo : sample;
    v_cl   = (v_lo > cal.hi) ? cal.hi : v_lo;
    seg_c  = v_cl < cal.mid;
    start  = seg_c ? cal.lo : cal.mid;
    endp   = seg_c ? cal.mid : cal.hi;
    diff_c = v_cl - start;
    den_c  = endp - start;
    // positive out_low counts as 0
    span_c = seg_c ? (out_low[7] ? 8'(8'd0 - out_low) : 8'd0) : {1'b0, out_high};
  end

  logic [7:0] s0_diff, s0_den, s0_span;
  logic       s0_seg;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_diff <= diff_c;
      s0_den  <= den_c;
      s0_span <= span_c;
      s0_seg  <= seg_c;
    end
  end

  // stage 1: multiply
  logic [15:0]      prod;
  logic [NUM_W-1:0] s1_num;
  logic [7:0]       s1_den;
  logic             s1_seg;

  assign prod = {8'd0, s0_diff} * {8'd0, s0_span};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_num <= NUM_W'(prod);
      s1_den <= s0_den;
      s1_seg <= s0_seg;
    end
  end

  // divider stages
  logic [7:0]       d_rem [DIV_STAGES+1];
  logic [NUM_W-1:0] d_num [DIV_STAGES+1];
  logic [NUM_W-1:0] d_quo [DIV_STAGES+1];
  logic [7:0]       d_den [DIV_STAGES+1];
  logic             d_seg [DIV_STAGES+1];

  assign d_rem[0] = 8'd0;
  assign d_num[0] = s1_num;
  assign d_quo[0] = '0;
  assign d_den[0] = s1_den;
  assign d_seg[0] = s1_seg;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    jacm_div_stage #(
      .BPS   (DIV_BPS),
      .NUM_W (NUM_W)
    ) u_stage (
      .clk     (clk),
      .en      (en[2+k]),
      .rem_in  (d_rem[k]),
      .num_in  (d_num[k]),
      .quo_in  (d_quo[k]),
      .den_in  (d_den[k]),
      .seg_in  (d_seg[k]),
      .rem_out (d_rem[k+1]),
      .num_out (d_num[k+1]),
      .quo_out (d_quo[k+1]),
      .den_out (d_den[k+1]),
      .seg_out (d_seg[k+1])
    );
  end

  // last stage: add segment start, saturate
  logic [NUM_W-1:0]        quo;
  logic [7:0]              base;
  logic signed [NUM_W+1:0] sum;
  logic [7:0]              pos_next;

  always_comb begin
    quo  = (d_den[DIV_STAGES] == 8'd0) ? '0 : d_quo[DIV_STAGES];
    base = (d_seg[DIV_STAGES] && out_low[7]) ? out_low : 8'd0;
    sum  = $signed({2'b00, quo}) + $signed({{(NUM_W-6){base[7]}}, base});
    if (sum > $signed((NUM_W+2)'(127))) begin
      pos_next = 8'h7F;
    end else if (sum < -$signed((NUM_W+2)'(128))) begin
      pos_next = 8'h80;
    end else begin
      pos_next = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      pos <= pos_next;
    end
  end

endmodule

>>> rtl/joystick_axis_calibrated_map.sv
// Top level of the calibrated joystick axis map.
// Depends on jacm_pkg, jacm_regs, jacm_lane (and through it jacm_div_stage).
//
// Usage:
//  - Input stream s_*: one transfer carries a raw X/Y sample pair.
//  - Output stream m_*: one transfer per input, pos_x/pos_y are the clamped,
//    piecewise-linear mapped positions, echo_x/echo_y the raw bytes.
//  - APB port: eight calibration registers at byte offsets 0x00..0x1C; write
//    them only while the pipeline is empty. Software keeps low<=mid<=high.
//  - Pipeline: with DIV_BPS=3 the stages are clamp, multiply, five divider
//    stages and offset/saturate; in general DIV_BPS sets how many divider
//    stages there are. The divider stages set the depth.
//  - Throughput: one pair per cycle unless the receiver stalls. Each stage has
//    its own valid bit and loads whenever it is empty or the stage after it
//    moves, so bubbles are squeezed out and input flows while a result waits.
//  - Receiver stall: the output register holds; stages fill up behind it,
//    and s_tready drops only when every stage holds an item.
//  - Reset (rst, synchronous): clears all valid bits and loads the default
//    calibration (0/128/255 per axis, out_low -100, out_high 100).
module joystick_axis_calibrated_map #(
  parameter int DIV_BPS = jacm_pkg::DIV_BPS
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] sample_x, [15:8] sample_y
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] pos_x, [15:8] pos_y, [23:16] echo_x,
                                 // [31:24] echo_y
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jacm_pkg::ADDR_W-1:0] paddr,
  input  logic [jacm_pkg::DATA_W-1:0] pwdata,
  output logic [jacm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int DIV_STAGES = (jacm_pkg::PROD_W + DIV_BPS - 1) / DIV_BPS;
  localparam int NSTG       = DIV_STAGES + 3;

  jacm_pkg::cal_t cal;

  jacm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  // pipeline control: a stage loads when empty or when its successor moves
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTG-1];

  // raw bytes ride alongside the datapath
  logic [15:0] echo_pipe [NSTG];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      echo_pipe[0] <= s_tdata;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        echo_pipe[k] <= echo_pipe[k-1];
      end
    end
  end

  logic [7:0] pos_x, pos_y;

  jacm_lane #(.DIV_BPS(DIV_BPS)) u_lane_x (
    .clk      (clk),
    .en       (en),
    .sample   (s_tdata[7:0]),
    .cal      (cal.x),
    .out_low  (cal.out_low),
    .out_high (cal.out_high),
    .pos      (pos_x)
  );

  jacm_lane #(.DIV_BPS(DIV_BPS)) u_lane_y (
    .clk      (clk),
    .en       (en),
    .sample   (s_tdata[15:8]),
    .cal      (cal.y),
    .out_low  (cal.out_low),
    .out_high (cal.out_high),
    .pos      (pos_y)
  );

  assign m_tdata = {echo_pipe[NSTG-1], pos_y, pos_x};

  // an accepted pair always lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted transfer not captured in first stage");

  // input is refused only when the whole pipeline is full and stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (!s_tready) |-> ((&vld) && !m_tready))
    else $error("input stalled with room in the pipeline");

  // an empty first stage always takes input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!vld[0]) |-> s_tready)
    else $error("empty first stage not ready");

  // after an output transfer the next output valid comes from the stage before
  a_out_advance: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (m_tvalid == $past(vld[NSTG-2])))
    else $error("output stage did not advance from its predecessor");

endmodule
